// ===== design/pchc_pkg.sv =====
// ----------------------------------------------------------------------------
// pchc_pkg
// Types, constants and the CRC-32 byte step for the package header checker.
// ----------------------------------------------------------------------------
package pchc_pkg;

  localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
  localparam logic [31:0] MIN_PKG_BYTES   = 32'd128;
  localparam logic [31:0] MAGIC_DPUI      = 32'h4955_5044;
  localparam logic [31:0] CRC_FIELD_FIRST = 32'd12;
  localparam logic [31:0] CRC_FIELD_END   = 32'd16;
  localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;
  localparam logic [15:0] VERSION_BASE    = 16'd1;
  localparam logic [15:0] VERSION_DPUI    = 16'd2;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TRUNC   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_SIZE    = 3'd4,
    ST_CRC     = 3'd5
  } status_t;

  // Reflected CRC-32, one byte: eight shift/xor steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== design/package_header_crc_checker.sv =====
// ----------------------------------------------------------------------------
// package_header_crc_checker
// Streams a package one byte per beat, checks its header and CRC-32.
// ----------------------------------------------------------------------------
// One byte beat can be taken every clock. The input stalls only while a byte
// marked last waits behind a result beat that the output side is holding.
// Each byte lands in an input register. From there one short stage
// updates the byte count, the header captures (magic at 0-3, version at 4-5,
// size at 8-11, stored CRC at 12-15, all little-endian) and the reflected
// CRC-32 (bytes 12-15 enter as zero). The CRC byte step is the longest path.
// On the beat marked last the stage loads one result beat (status, stored
// CRC, computed CRC, saturating length) into the output register and clears
// the package state, so the next package may follow with no gap. The last
// byte passes the input register and then the stage before its result beat
// is valid in the output register. Status is the first failing check of:
// truncated (under 128 bytes), magic mismatch, version (1, or 2 with magic
// "DPUI"), size mismatch, CRC mismatch; else ok. Write cfg_data (expected
// magic, first character in the low byte) only while no package is in
// flight.
// ----------------------------------------------------------------------------
module package_header_crc_checker (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_header_crc,
  output logic [31:0] out_computed_crc,
  output logic [31:0] out_package_length,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import pchc_pkg::*;

  // configuration
  logic [31:0] magic_cfg_r;

  // input register
  logic        v1_r, v1_nxt;
  logic [7:0]  b1_r;
  logic        l1_r;

  // package state
  logic [31:0] count_r, count_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] magic_r, magic_nxt;
  logic [15:0] version_r, version_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] stored_r, stored_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  status_t     status_r, status_nxt;
  logic [31:0] hdr_crc_r, comp_crc_r, len_r;

  logic        in_acc, fire, emit;
  logic [31:0] pos;
  logic        in_magic, in_version, in_size, in_crcf;
  logic [7:0]  fed;
  logic [31:0] crc_step, count_inc, computed;
  logic [31:0] magic_new, size_new, stored_new;
  logic [15:0] version_new;
  logic        version_ok;

  // Stage fires unless it would emit into a held result.
  assign fire     = v1_r && !(l1_r && out_valid_r && out_stall);
  assign emit     = fire && l1_r;
  assign in_stall = v1_r && !fire;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = !v1_r;

  // Header field decode by byte position.
  assign pos        = count_r;
  assign in_magic   = (pos[31:2] == 30'd0);
  assign in_version = (pos[31:1] == 31'd2);
  assign in_size    = (pos[31:2] == 30'd2);
  assign in_crcf    = (pos >= CRC_FIELD_FIRST) && (pos < CRC_FIELD_END);

  assign fed       = in_crcf ? 8'd0 : b1_r;
  assign crc_step  = crc_byte(crc_r, fed);
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 32'd1;
  assign computed  = ~crc_step;

  // Captures including the current byte: each lane is written once, in order.
  always_comb begin
    magic_new   = magic_r;
    version_new = version_r;
    size_new    = size_r;
    stored_new  = stored_r;
    if (in_magic) begin
      magic_new[8*pos[1:0] +: 8] = b1_r;
    end else if (in_version) begin
      version_new[8*pos[0] +: 8] = b1_r;
    end else if (in_size) begin
      size_new[8*pos[1:0] +: 8] = b1_r;
    end else if (in_crcf) begin
      stored_new[8*pos[1:0] +: 8] = b1_r;
    end
  end

  assign version_ok = (version_new == VERSION_BASE) ||
                      ((magic_new == MAGIC_DPUI) && (version_new == VERSION_DPUI));

  // First failing check wins.
  always_comb begin
    if (count_inc < MIN_PKG_BYTES)       status_nxt = ST_TRUNC;
    else if (magic_new != magic_cfg_r)   status_nxt = ST_MAGIC;
    else if (!version_ok)                status_nxt = ST_VERSION;
    else if (size_new != count_inc)      status_nxt = ST_SIZE;
    else if (stored_new != computed)     status_nxt = ST_CRC;
    else                                 status_nxt = ST_OK;
  end

  // Advance state on fire; drop back to reset values after the last byte.
  always_comb begin
    count_nxt   = count_r;
    crc_nxt     = crc_r;
    magic_nxt   = magic_r;
    version_nxt = version_r;
    size_nxt    = size_r;
    stored_nxt  = stored_r;
    if (emit) begin
      count_nxt   = '0;
      crc_nxt     = CRC_INIT;
      magic_nxt   = '0;
      version_nxt = '0;
      size_nxt    = '0;
      stored_nxt  = '0;
    end else if (fire) begin
      count_nxt   = count_inc;
      crc_nxt     = crc_step;
      magic_nxt   = magic_new;
      version_nxt = version_new;
      size_nxt    = size_new;
      stored_nxt  = stored_new;
    end
  end

  always_comb begin
    v1_nxt = v1_r;
    if (in_acc)    v1_nxt = 1'b1;
    else if (fire) v1_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit)                  out_valid_nxt = 1'b1;
    else if (!out_stall)       out_valid_nxt = 1'b0;
  end

  // Control and package state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_cfg_r <= '0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      crc_r       <= CRC_INIT;
      magic_r     <= '0;
      version_r   <= '0;
      size_r      <= '0;
      stored_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) magic_cfg_r <= cfg_data;
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      crc_r       <= crc_nxt;
      magic_r     <= magic_nxt;
      version_r   <= version_nxt;
      size_r      <= size_nxt;
      stored_r    <= stored_nxt;
    end
  end

  // Payload registers: hold unless loaded.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      b1_r <= in_data_byte;
      l1_r <= in_last_byte;
    end
    if (emit) begin
      status_r   <= status_nxt;
      hdr_crc_r  <= stored_new;
      comp_crc_r <= computed;
      len_r      <= count_inc;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_header_crc     = hdr_crc_r;
  assign out_computed_crc   = comp_crc_r;
  assign out_package_length = len_r;

  // Stall only while a byte is held in the input register.
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r)
    else $error("input stalled with empty input register");

  // After a result is loaded the package state starts fresh.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (count_r == '0) && (crc_r == CRC_INIT) && (magic_r == '0))
    else $error("package state not cleared after last byte");

  // An ok result implies matching CRCs and a full-size package.
  a_ok_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_OK)) |->
      (hdr_crc_r == comp_crc_r) && (len_r >= MIN_PKG_BYTES))
    else $error("ok status with failing checks");

  // Byte counter holds at its maximum.
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !l1_r && (count_r == COUNT_MAX)) |=> (count_r == COUNT_MAX))
    else $error("byte counter wrapped");

endmodule

// ===== dv/tb_package_header_crc_checker.sv =====
// ----------------------------------------------------------------------------
// tb_package_header_crc_checker
// Self-checking bench for the package header and CRC-32 checker.
// ----------------------------------------------------------------------------
// Packages are built here with correct or deliberately broken header fields
// and stored CRC, then streamed in one byte beat at a time. A predictor
// follows every accepted byte and queues the status beat that each package
// must produce. A checker pops that queue on every result beat and compares
// all four fields. Both sides insert random gaps, and some phases run with no
// gaps, with a long result hold-off, or with the sender paused until drained.
// ----------------------------------------------------------------------------
module tb_package_header_crc_checker;
  import pchc_pkg::*;

  localparam int QUIET_LIMIT = 5000;   // cycles with no beat on any channel
  localparam int DRAIN_PAUSE = 4;      // settle margin after draining
  localparam int HOLD_CYCLES = 400;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    status_t     status;
    logic [31:0] hdr_crc;
    logic [31:0] calc_crc;
    logic [31:0] pkg_len;
  } pkg_verdict_t;

  // Drive every input to a known value from time zero.
  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte     = 8'd0;
  logic        in_last_byte     = 1'b0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_header_crc;
  logic [31:0] out_computed_crc;
  logic [31:0] out_package_length;
  logic        cfg_valid        = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data         = 32'd0;

  // Predictor copy of the block: register and per-package captures.
  logic [31:0] cur_magic   = 32'd0;
  logic [31:0] run_count   = 32'd0;
  logic [31:0] run_crc     = CRC_INIT;
  logic [31:0] run_magic   = 32'd0;
  logic [15:0] run_version = 16'd0;
  logic [31:0] run_size    = 32'd0;
  logic [31:0] run_stored  = 32'd0;

  pkg_verdict_t verdict_q[$];
  logic [7:0]   pkg_bytes[$];

  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  int  hold_left      = 0;
  bit  gaps_on        = 1'b1;

  package_header_crc_checker i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_header_crc     (out_header_crc),
    .out_computed_crc   (out_computed_crc),
    .out_package_length (out_package_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Bit-serial reflected CRC-32: fold one byte in, low bit first.
  function automatic logic [31:0] crc32_feed(input logic [31:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // Advance the predictor by one accepted byte; on the last byte queue the
  // expected status beat and clear the package state.
  function automatic void predict_verdict(input logic [7:0] b, input logic lst);
    logic [31:0]  pos;
    logic [7:0]   fed;
    pkg_verdict_t v;
    pos = run_count;
    fed = b;
    if (pos < 4) begin
      run_magic[8*pos[1:0] +: 8] = b;
    end else if (pos < 6) begin
      run_version[8*pos[0] +: 8] = b;
    end else if (pos >= 8 && pos < 12) begin
      run_size[8*pos[1:0] +: 8] = b;
    end else if (pos >= CRC_FIELD_FIRST && pos < CRC_FIELD_END) begin
      // CRC field: capture it, but feed zeros into the running CRC.
      run_stored[8*pos[1:0] +: 8] = b;
      fed = 8'd0;
    end
    run_crc = crc32_feed(run_crc, fed);
    if (run_count != COUNT_MAX) run_count++;
    if (!lst) return;

    v.hdr_crc  = run_stored;
    v.calc_crc = ~run_crc;
    v.pkg_len  = run_count;
    // First failing check wins.
    if (run_count < MIN_PKG_BYTES)
      v.status = ST_TRUNC;
    else if (run_magic != cur_magic)
      v.status = ST_MAGIC;
    else if (run_version != VERSION_BASE &&
             !(run_magic == MAGIC_DPUI && run_version == VERSION_DPUI))
      v.status = ST_VERSION;
    else if (run_size != run_count)
      v.status = ST_SIZE;
    else if (run_stored != v.calc_crc)
      v.status = ST_CRC;
    else
      v.status = ST_OK;
    verdict_q.push_back(v);

    run_count   = 32'd0;
    run_crc     = CRC_INIT;
    run_magic   = 32'd0;
    run_version = 16'd0;
    run_size    = 32'd0;
    run_stored  = 32'd0;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: compare every result beat with the oldest expectation.
  // --------------------------------------------------------------------------

  function automatic void compare_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("mismatch on %s: expected %h, got %h", fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    pkg_verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result beat: status %0d length %0d",
                   out_status, out_package_length);
      end else begin
        want = verdict_q.pop_front();
        compare_field("status", 32'(want.status), 32'(out_status));
        compare_field("header_crc", want.hdr_crc, out_header_crc);
        compare_field("computed_crc", want.calc_crc, out_computed_crc);
        compare_field("package_length", want.pkg_len, out_package_length);
      end
    end
  end

  // Result side: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= gaps_on && ($urandom_range(99) < 37);
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one byte beat, hold it until accepted, then predict it. Valid is
  // left high so a following beat can go out with no bubble.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 37) begin
      in_valid     <= 1'b0;
      in_data_byte <= 8'($urandom);
      in_last_byte <= 1'($urandom);
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_verdict(b, lst);
  endtask

  task automatic send_package();
    int n;
    n = pkg_bytes.size();
    for (int i = 0; i < n; i++) send_byte(pkg_bytes[i], i == n - 1);
  endtask

  // Drop valid and wait until every expected result has arrived.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Write the expected magic while the block is idle.
  task automatic write_magic(input logic [31:0] m);
    drain();
    repeat (DRAIN_PAUSE) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_magic = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= 32'($urandom);
  endtask

  // Build a package of len bytes. fill: 0 random body, 1 all zero, 2 all ones.
  // Header fields that fit are overwritten; size and stored CRC are either
  // correct or deliberately wrong.
  task automatic make_package(input logic [31:0] magic, input logic [15:0] version,
                              input int len, input bit size_ok, input bit crc_ok,
                              input int fill);
    logic [31:0] sz;
    logic [31:0] crc;
    pkg_bytes.delete();
    for (int i = 0; i < len; i++)
      pkg_bytes.push_back(fill == 1 ? 8'h00 : fill == 2 ? 8'hFF : 8'($urandom));
    sz = size_ok ? 32'(len) : 32'(len) ^ 32'($urandom_range(255, 1));
    for (int k = 0; k < 12 && k < len; k++) begin
      if (k < 4)
        pkg_bytes[k] = magic[8*k +: 8];
      else if (k < 6)
        pkg_bytes[k] = version[8*(k-4) +: 8];
      else if (k >= 8)
        pkg_bytes[k] = sz[8*(k-8) +: 8];
    end
    crc = CRC_INIT;
    for (int i = 0; i < len; i++)
      crc = crc32_feed(crc, (i >= 12 && i < 16) ? 8'h00 : pkg_bytes[i]);
    crc = ~crc;
    if (!crc_ok) crc = crc ^ (32'd1 << $urandom_range(31));
    for (int k = 12; k < 16 && k < len; k++)
      pkg_bytes[k] = crc[8*(k-12) +: 8];
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset value of the magic register, and the truncation boundary. The
  // full-length package matches the reset magic and fails only on size.
  task automatic test_reset_and_length();
    make_package(32'd0, VERSION_BASE, 1, 1'b1, 1'b1, 0);
    send_package();                                   // one-byte package
    make_package(32'd0, VERSION_BASE, 14, 1'b1, 1'b1, 0);
    send_package();                                   // ends inside CRC field
    make_package(32'd0, VERSION_BASE, 128, 1'b0, 1'b1, 1);
    send_package();                                   // minimum length, zeros
  endtask

  // Magic check, then the version rule with and without DPUI; DPUI with
  // version 2 passes every check.
  task automatic test_header_checks();
    write_magic(32'h4443_4241);
    make_package(32'h4443_4240, VERSION_BASE, 128, 1'b1, 1'b1, 0);
    send_package();                                   // magic mismatch
    make_package(cur_magic, VERSION_DPUI, 128, 1'b0, 1'b0, 0);
    send_package();                                   // version beats size/CRC
    write_magic(MAGIC_DPUI);
    make_package(cur_magic, VERSION_DPUI, 128, 1'b1, 1'b1, 0);
    send_package();                                   // ok
  endtask

  // All-one bytes with an all-ones magic, stored CRC off by one bit, and a
  // short all-zero package.
  task automatic test_data_extremes();
    write_magic(32'hFFFF_FFFF);
    make_package(cur_magic, VERSION_BASE, 128, 1'b1, 1'b0, 2);
    send_package();                                   // CRC mismatch
    make_package(cur_magic, 16'hFFFF, 16, 1'b1, 1'b1, 1);
    send_package();
  endtask

  // Back-to-back beats on both sides, no gaps at all.
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    for (int p = 0; p < 16; p++) begin
      make_package(32'($urandom), 16'($urandom), $urandom_range(3, 1), 1'b1, 1'b1, 0);
      send_package();
    end
    drain();
    gaps_on = 1'b1;
  endtask

  // Hold the result side off for a long stretch while short packages keep
  // coming, so the block fills and stalls its input.
  task automatic test_result_hold();
    drain();
    hold_left = HOLD_CYCLES;
    for (int p = 0; p < 6; p++) begin
      make_package(32'($urandom), 16'($urandom), $urandom_range(2, 1), 1'b1, 1'b1, 0);
      send_package();
    end
  endtask

  // Pause the sender until every result is back, then resume.
  task automatic test_sender_pause();
    make_package(cur_magic, VERSION_BASE, 6, 1'b1, 1'b1, 0);
    send_package();
    drain();
    repeat ($urandom_range(20, 5)) @(posedge clk);
    make_package(cur_magic, VERSION_BASE, 6, 1'b1, 1'b1, 0);
    send_package();
  endtask

  // Short packages with random content, some with a correct header start,
  // some pure noise, under several magic values.
  task automatic test_random_packages();
    logic [31:0] phase_magic[3];
    int          kind;
    phase_magic[0] = 32'($urandom);
    phase_magic[1] = MAGIC_DPUI;
    phase_magic[2] = 32'hFFFF_FFFF;
    for (int ph = 0; ph < 3; ph++) begin
      write_magic(phase_magic[ph]);
      for (int p = 0; p < 3; p++) begin
        kind = $urandom_range(3);
        case (kind) inside
          [0:1]:   make_package(cur_magic, VERSION_BASE, $urandom_range(16, 1),
                                1'b1, 1'b1, 0);
          default: make_package(32'($urandom), 16'($urandom), $urandom_range(8, 1),
                                1'($urandom), 1'($urandom), 0);
        endcase
        send_package();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_and_length();
    test_header_checks();
    test_data_extremes();
    test_back_to_back();
    test_result_hold();
    test_sender_pause();
    test_random_packages();

    // Let the last results out, then allow a short settle time.
    drain();
    repeat (2 * DRAIN_PAUSE) @(posedge clk);
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
